// ===== rtl/rsc_pkg.sv =====
// rsc_pkg: shared types and constants for the postfix stack calculator
// no dependencies; imported by rsc_div, rpn_stack_calculator_unit and the testbench

package rsc_pkg;

    localparam int DATA_W = 32;

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_END  = 3'd5;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [DATA_W-1:0] operand_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     status;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV
    } t_state;

endpackage

// ===== rtl/rsc_ram.sv =====
// rsc_ram: generic single-write, single-read ram with registered read data
// no dependencies

module rsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rsc_div.sv =====
// rsc_div: iterative signed divider, one quotient bit per cycle, truncating
// depends on rsc_pkg

module rsc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rsc_pkg::DATA_W-1:0]   i_dividend,
    input  logic [rsc_pkg::DATA_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [rsc_pkg::DATA_W-1:0]   o_quotient
);
    import rsc_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_neg, n_neg;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_quo, n_quo;
    logic [DATA_W-1:0] r_dvs, n_dvs;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    always_comb begin
        shifted = {r_rem, r_quo[DATA_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_neg  = i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            n_rem  = '0;
            n_quo  = i_dividend[DATA_W-1] ? -i_dividend : i_dividend;
            n_dvs  = i_divisor[DATA_W-1] ? -i_divisor : i_divisor;
        end else if (r_busy) begin
            if (!diff[DATA_W]) begin
                n_rem = diff[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -r_quo : r_quo;

endmodule

// ===== rtl/rpn_stack_calculator_unit.sv =====
// rpn_stack_calculator_unit: postfix integer evaluator over a bounded stack
// depends on rsc_pkg, rsc_ram (stack entries below the top), rsc_div
// push, end, spare opcodes, an operator on under two values: done on acceptance;
// add/sub/mul, divide by zero: ram read state; divide: ram read, then bit-serial
// divider; input stalls until idle; latency: an end transaction's result is valid
// the cycle after acceptance; reset: synchronous, active low, no ram clear

module rpn_stack_calculator_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rsc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rsc_pkg::t_out_item o_out_data
);
    import rsc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [DATA_W-1:0] r_top, n_top;
    logic [2:0]        r_op, n_op;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              accept;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;
    logic [CW-1:0]     count_m1;
    logic [CW-1:0]     count_m2;
    logic [DATA_W-1:0] product;

    assign o_in_stall = (r_state != ST_IDLE) ||
                        (i_in_data.opcode == OP_END && r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign count_m1   = r_count - 1'b1;
    assign count_m2   = r_count - TWO_C;
    assign mem_raddr  = count_m2[AW-1:0];
    assign mem_waddr  = count_m1[AW-1:0];
    assign product    = mem_rdata * r_top;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && r_count >= TWO_C &&
                    (i_in_data.opcode == OP_ADD || i_in_data.opcode == OP_SUB ||
                     i_in_data.opcode == OP_MUL || i_in_data.opcode == OP_DIV)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_op == OP_DIV && r_top != '0) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count     = r_count;
        n_top       = r_top;
        n_op        = r_op;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        div_start   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op = i_in_data.opcode;
                    priority if (i_in_data.opcode == OP_PUSH) begin
                        if (r_count < DEPTH_C) begin
                            mem_we  = (r_count != '0);
                            n_top   = i_in_data.operand_value;
                            n_count = r_count + 1'b1;
                        end
                    end else if (i_in_data.opcode == OP_ADD ||
                                 i_in_data.opcode == OP_SUB ||
                                 i_in_data.opcode == OP_MUL ||
                                 i_in_data.opcode == OP_DIV) begin
                        if (r_count < TWO_C) begin
                            n_count = '0;
                        end
                    end else if (i_in_data.opcode == OP_END) begin
                        n_out_valid = 1'b1;
                        if (r_count == '0) begin
                            n_out.result_value = '0;
                            n_out.status       = STATUS_EMPTY;
                        end else begin
                            n_out.result_value = r_top;
                            n_out.status       = STATUS_OK;
                        end
                        n_count = '0;
                    end else begin
                        n_count = r_count;
                    end
                end
            end
            ST_READ: begin
                unique case (r_op)
                    OP_ADD: begin
                        n_top   = mem_rdata + r_top;
                        n_count = count_m1;
                    end
                    OP_SUB: begin
                        n_top   = mem_rdata - r_top;
                        n_count = count_m1;
                    end
                    OP_MUL: begin
                        n_top   = product;
                        n_count = count_m1;
                    end
                    default: begin
                        if (r_top == '0) begin
                            n_count = '0;
                        end else begin
                            div_start = 1'b1;
                        end
                    end
                endcase
            end
            ST_DIV: begin
                if (div_done) begin
                    n_top   = div_quo;
                    n_count = count_m1;
                end
            end
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_top <= n_top;
        r_op  <= n_op;
        r_out <= n_out;
    end

    rsc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_top),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mem_rdata),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for rpn_stack_calculator_unit
// depends on rsc_pkg for the token and result types, opcodes and status codes
// queue-fed driver, clocked monitor and a local postfix stack predictor

module testbench;

    import rsc_pkg::*;

    localparam int STACK_DEPTH = 32;
    localparam int RANDOM_ITEMS = 1900;
    localparam int CALM_ITEMS = 150;
    localparam int HOLD_AT = 500;
    localparam int LONG_HOLD = 300;
    localparam int PAUSE_AT = 1200;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_PRINTED = 40;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    t_in_item  pending_tokens[$];
    t_out_item expected_results[$];
    t_out_item expected_head;

    logic signed [DATA_W-1:0] stack_mem[STACK_DEPTH];
    int stack_depth = 0;

    int total_tokens = 0;
    int counted_tokens = 0;
    int tokens_accepted = 0;
    int ends_accepted = 0;
    int results_checked = 0;
    int error_count = 0;
    int idle_cycles = 0;

    int divides_done = 0;
    int zero_div_clears = 0;
    int short_clears = 0;
    int full_drops = 0;
    int empty_ends = 0;

    int  send_gap = 0;
    bit  pause_active = 1'b0;
    bit  pause_done = 1'b0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  calm_tail = 1'b0;

    rpn_stack_calculator_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTED) begin
            $display("mismatch: %s got %h want %h (result %0d)", what, got, want,
                     results_checked);
        end
        error_count++;
    endtask

    function automatic void stack_push(input logic signed [DATA_W-1:0] value);
        if (stack_depth < STACK_DEPTH) begin
            stack_mem[stack_depth] = value;
            stack_depth++;
        end else begin
            full_drops++;
        end
    endfunction

    function automatic void predict_token(input t_in_item tok);
        logic signed [DATA_W-1:0] lhs;
        logic signed [DATA_W-1:0] rhs;
        logic signed [DATA_W-1:0] res;
        t_out_item                outcome;
        case (tok.opcode)
            OP_PUSH: begin
                stack_push(tok.operand_value);
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (stack_depth < 2) begin
                    stack_depth = 0;
                    short_clears++;
                end else begin
                    rhs = stack_mem[stack_depth-1];
                    lhs = stack_mem[stack_depth-2];
                    stack_depth -= 2;
                    if (tok.opcode == OP_DIV && rhs == 0) begin
                        stack_depth = 0;
                        zero_div_clears++;
                    end else begin
                        case (tok.opcode)
                            OP_ADD: res = lhs + rhs;
                            OP_SUB: res = lhs - rhs;
                            OP_MUL: res = lhs * rhs;
                            default: begin
                                divides_done++;
                                res = (lhs == MOST_NEG && rhs == -1) ? MOST_NEG : lhs / rhs;
                            end
                        endcase
                        stack_push(res);
                    end
                end
            end
            OP_END: begin
                if (stack_depth == 0) begin
                    outcome.result_value = '0;
                    outcome.status = STATUS_EMPTY;
                    empty_ends++;
                end else begin
                    outcome.result_value = stack_mem[stack_depth-1];
                    outcome.status = STATUS_OK;
                end
                stack_depth = 0;
                expected_results.push_back(outcome);
            end
            default: ;
        endcase
    endfunction

    function automatic void put(input logic [2:0] op, input logic signed [DATA_W-1:0] value);
        t_in_item tok;
        tok.opcode = op;
        tok.operand_value = value;
        pending_tokens.push_back(tok);
        total_tokens++;
        if (op <= OP_END) begin
            counted_tokens++;
        end
    endfunction

    function automatic void put_op(input logic [2:0] op);
        put(op, $urandom);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return MOST_NEG;
                    1: return MOST_POS;
                    2: return -1;
                    3: return 0;
                    default: return 1;
                endcase
            end
            1, 2, 3, 4: return int'($urandom_range(0, 40)) - 20;
            5, 6: return $urandom;
            default: return int'($urandom_range(0, 140000)) - 70000;
        endcase
    endfunction

    task automatic gen_expression(input int n_operands, input int push_bias);
        int pushed;
        int depth;
        pushed = 0;
        depth = 0;
        while (pushed < n_operands || depth > 1) begin
            if (depth < 2 || (pushed < n_operands && $urandom_range(0, 99) < push_bias)) begin
                put(OP_PUSH, pick_operand());
                pushed++;
                depth++;
            end else begin
                put_op(3'($urandom_range(OP_ADD, OP_DIV)));
                depth--;
            end
        end
        put_op(OP_END);
    endtask

    task automatic gen_broken();
        repeat ($urandom_range(0, 2)) put(OP_PUSH, pick_operand());
        repeat ($urandom_range(1, 3)) put_op(3'($urandom_range(OP_ADD, OP_DIV)));
        if ($urandom_range(0, 1) == 1) begin
            put_op(OP_END);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_token(i_in_data);
                tokens_accepted <= tokens_accepted + 1;
                if (i_in_data.opcode == OP_END) begin
                    ends_accepted <= ends_accepted + 1;
                end
            end
            if (i_in_valid && o_in_stall) begin
                // hold the offered transaction
            end else if (pause_active) begin
                i_in_valid <= 1'b0;
                if (ends_accepted == results_checked) begin
                    pause_active <= 1'b0;
                end
            end else if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (!pause_done && tokens_accepted >= PAUSE_AT) begin
                i_in_valid <= 1'b0;
                pause_active <= 1'b1;
                pause_done <= 1'b1;
            end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
                i_in_valid <= 1'b0;
                send_gap <= $urandom_range(0, 15);
            end else if (pending_tokens.size() != 0) begin
                i_in_data <= pending_tokens.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
            calm_tail <= pending_tokens.size() < CALM_ITEMS;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", o_out_data.result_value, '0);
                end else begin
                    expected_head = expected_results.pop_front();
                    results_checked <= results_checked + 1;
                    if (o_out_data.result_value !== expected_head.result_value) begin
                        report_mismatch("result_value", o_out_data.result_value,
                                        expected_head.result_value);
                    end
                    if (o_out_data.status !== expected_head.status) begin
                        report_mismatch("status", 32'(o_out_data.status),
                                        32'(expected_head.status));
                    end
                end
            end
            if (!hold_done && tokens_accepted >= HOLD_AT) begin
                i_out_stall <= 1'b1;
                hold_left <= LONG_HOLD;
                hold_done <= 1'b1;
            end else if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 15);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", idle_cycles);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        // end on an empty stack
        put_op(OP_END);
        // operand order for subtract
        put(OP_PUSH, 5);
        put(OP_PUSH, 3);
        put_op(OP_SUB);
        put_op(OP_END);
        // sum wraps
        put(OP_PUSH, MOST_POS);
        put(OP_PUSH, 1);
        put_op(OP_ADD);
        put_op(OP_END);
        // most negative divided by minus one wraps
        put(OP_PUSH, MOST_NEG);
        put(OP_PUSH, -1);
        put_op(OP_DIV);
        put_op(OP_END);
        // quotient truncates toward zero
        put(OP_PUSH, -7);
        put(OP_PUSH, 2);
        put_op(OP_DIV);
        put_op(OP_END);
        // divide by zero clears
        put(OP_PUSH, 12345);
        put(OP_PUSH, 0);
        put_op(OP_DIV);
        put_op(OP_END);
        // operator with one value clears, product wraps
        put(OP_PUSH, 32'sh0001_0000);
        put_op(OP_MUL);
        put_op(OP_END);
        put(OP_PUSH, 32'sh0001_0000);
        put(OP_PUSH, 32'sh0001_0000);
        put_op(OP_MUL);
        put_op(OP_END);
        // unused opcodes leave the stack alone
        put(OP_PUSH, 9);
        put_op(OP_SPARE_LO);
        put_op(OP_SPARE_HI);
        put_op(OP_END);
        // push onto a full stack is dropped
        for (int i = 0; i < STACK_DEPTH + 2; i++) begin
            put(OP_PUSH, 100 + i);
        end
        put_op(OP_END);

        while (counted_tokens < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0: gen_expression($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4), 95);
                1, 2: repeat ($urandom_range(1, 6)) put(3'($urandom_range(0, 7)), $urandom);
                3, 4: gen_broken();
                default: gen_expression($urandom_range(1, 8), 50);
            endcase
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (tokens_accepted != total_tokens || results_checked != ends_accepted) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch("results never arrived", expected_results.size(), '0);
        end

        $display("covered %0d tokens and %0d results, %0d of them on an empty stack",
                 tokens_accepted, results_checked, empty_ends);
        $display("%0d divides, %0d divide-by-zero clears, %0d underflow clears, %0d full drops",
                 divides_done, zero_div_clears, short_clears, full_drops);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rsc_pkg.sv
rtl/rsc_ram.sv
rtl/rsc_div.sv
rtl/rpn_stack_calculator_unit.sv
bench/testbench.sv
